>>> sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/rbs_pkg.sv
// Types and constants for the radio burst scheduler.
package rbs_pkg;

  localparam int unsigned SLOT_COUNT = 2048;
  localparam int unsigned SLOT_W     = 11;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned REM_W       = 6;

  localparam logic [7:0]  THRESHOLD_RST = 8'd8;
  localparam logic [5:0]  LIMIT_RST     = 6'd20;
  localparam logic [15:0] TIMEOUT_RST   = 16'(4 * 500);

  localparam logic [CFG_IDX_W-1:0] REG_BURST_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_TIMEOUT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_TIMEOUT  = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROLL,
    S_DECIDE,
    S_DATA,
    S_STAT
  } rbs_state_t;

  typedef struct packed {
    logic capture;
    logic roll;
    logic decide;
    logic emit_data;
    logic emit_status;
  } rbs_cmd_t;

  typedef struct packed {
    logic out_free;
    logic burst;
    logic plain_status;
    logic status_due;
    logic rem_one;
  } rbs_sts_t;

endpackage

>>> sv/rbs_ctrl.sv
// Controller state machine for the radio burst scheduler.
`include "assert_macros.svh"

module rbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rbs_pkg::rbs_sts_t sts,
  output rbs_pkg::rbs_cmd_t cmd
);
  import rbs_pkg::*;

  rbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ROLL;
        end
      end
      S_ROLL: begin
        cmd.roll  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.burst) begin
          state_nxt = S_DATA;
        end else if (sts.plain_status) begin
          state_nxt = S_STAT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          if (sts.rem_one) begin
            state_nxt = sts.status_due ? S_STAT : S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_accept_to_roll, (in_tvalid && in_tready) |=> (state_r == S_ROLL), "accepted poll did not start evaluation")
  `ASSERT_CLK(a_status_ends_poll, cmd.emit_status |=> (state_r == S_IDLE), "status beat did not end the poll")
  `ASSERT_CLK(a_emit_needs_room, (cmd.emit_data || cmd.emit_status) |-> sts.out_free, "beat loaded into a full output register")

endmodule

>>> sv/rbs_datapath.sv
// Datapath: configuration, scheduler state, poll evaluation and output register.
`include "assert_macros.svh"

module rbs_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [rbs_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  rbs_pkg::rbs_cmd_t                   cmd,
  output rbs_pkg::rbs_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rbs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [rbs_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                out_tlast
);
  import rbs_pkg::*;

  // configuration
  logic [7:0]  thresh_r;
  logic [5:0]  limit_r;
  logic [15:0] data_to_r;
  logic [15:0] status_to_r;

  // scheduler state
  logic [31:0] rp_r, rp_nxt;
  logic [31:0] lb_r, lb_nxt;
  logic [31:0] ls_r, ls_nxt;
  logic [31:0] dcnt_r, dcnt_nxt;
  logic [31:0] scnt_r, scnt_nxt;

  // poll registers
  logic [31:0] now_r, wr_r, drop_r, fill_r;
  logic [REM_W-1:0] rem_r;
  logic burst_r, sdue_r;

  // output register
  logic                   ovalid_r, ovalid_nxt;
  logic [OUT_TDATA_W-1:0] odata_r;
  logic [OUT_TUSER_W-1:0] ouser_r;
  logic                   olast_r;

  // evaluation
  logic             negative, positive, data_due, status_due, burst;
  logic [5:0]       lim;
  logic [REM_W-1:0] cnt;
  logic             load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESHOLD_RST;
      limit_r     <= LIMIT_RST;
      data_to_r   <= TIMEOUT_RST;
      status_to_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BURST_THRESHOLD: thresh_r    <= cfg_data[7:0];
        REG_BURST_LIMIT:     limit_r     <= cfg_data[5:0];
        REG_DATA_TIMEOUT:    data_to_r   <= cfg_data;
        REG_STATUS_TIMEOUT:  status_to_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    negative   = fill_r[31];
    positive   = !negative && (fill_r != 32'd0);
    data_due   = (now_r - lb_r) > {16'd0, data_to_r};
    status_due = (now_r - ls_r) > {16'd0, status_to_r};
    burst      = (!negative && (fill_r > {24'd0, thresh_r})) || (data_due && positive);
    lim        = (limit_r == 6'd0) ? 6'd1 : limit_r;
    cnt        = (fill_r > {26'd0, lim}) ? lim : fill_r[REM_W-1:0];
  end

  assign load = cmd.emit_data || cmd.emit_status;

  always_comb begin
    rp_nxt   = rp_r;
    lb_nxt   = lb_r;
    ls_nxt   = ls_r;
    dcnt_nxt = dcnt_r;
    scnt_nxt = scnt_r;
    if (cmd.roll && ((now_r < lb_r) || (now_r < ls_r))) begin
      lb_nxt = now_r;
      ls_nxt = now_r;
    end
    if (cmd.decide && burst) begin
      lb_nxt = now_r;
    end
    if (cmd.emit_data) begin
      rp_nxt   = rp_r + 32'd1;
      dcnt_nxt = dcnt_r + 32'd1;
    end
    if (cmd.emit_status) begin
      scnt_nxt = scnt_r + 32'd1;
      ls_nxt   = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      lb_r   <= '0;
      ls_r   <= '0;
      dcnt_r <= '0;
      scnt_r <= '0;
    end else begin
      rp_r   <= rp_nxt;
      lb_r   <= lb_nxt;
      ls_r   <= ls_nxt;
      dcnt_r <= dcnt_nxt;
      scnt_r <= scnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r <= 1'b0;
      sdue_r  <= 1'b0;
      rem_r   <= '0;
    end else begin
      if (cmd.decide) begin
        burst_r <= burst;
        sdue_r  <= status_due;
        rem_r   <= cnt;
      end else if (cmd.emit_data) begin
        rem_r <= rem_r - REM_W'(1);
      end
    end
  end

  // poll payload; the fill is taken after capture, while stored times roll over
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r  <= in_tdata[31:0];
      wr_r   <= in_tdata[63:32];
      drop_r <= in_tdata[95:64];
    end
    if (cmd.roll) begin
      fill_r <= wr_r - rp_r;
    end
  end

  assign sts.out_free     = !ovalid_r || out_tready;
  assign sts.burst        = burst;
  assign sts.plain_status = status_due && (fill_r == 32'd0);
  assign sts.status_due   = sdue_r;
  assign sts.rem_one      = (rem_r == REM_W'(1));

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  // tdata: slot, data total, status total, stamp, dropped, zero pad
  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      odata_r <= {5'd0, 32'd0, 32'd0, 32'd0, dcnt_r + 32'd1, rp_r[SLOT_W-1:0]};
      ouser_r <= {1'b0, KIND_DATA};
      olast_r <= sts.rem_one && !sdue_r;
    end else if (cmd.emit_status) begin
      odata_r <= {5'd0, drop_r, now_r, scnt_r + 32'd1, dcnt_r, {SLOT_W{1'b0}}};
      ouser_r <= {burst_r, KIND_STATUS};
      olast_r <= 1'b1;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

  `ASSERT_CLK(a_rp_step, cmd.emit_data |=> (rp_r == $past(rp_r) + 32'd1), "read pointer did not advance on a data beat")
  `ASSERT_CLK(a_rem_nonzero, cmd.emit_data |-> (rem_r != '0), "data beat with no sends left")
  `ASSERT_CLK(a_stamp_time, cmd.emit_status |=> (ls_r == now_r), "status time not updated on status beat")

endmodule

>>> sv/radio_burst_scheduler_unit.sv
// Radio burst scheduler: poll in, burst of data-slot and status send beats out.
// A poll is accepted only while idle; evaluation follows (rollover and fill, then decision),
// then one send beat per cycle into the single output register, unless out_tready stalls it.
// A poll yields 0 to 64 beats and holds the unit until its last beat is loaded; the first beat
// reaches the ports through the roll and decide states and then the output register.
// rst_n (synchronous) zeroes pointers, times and counters and loads register defaults.
module radio_burst_scheduler_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] now_time, [63:32] write_pointer, [95:64] drop_count
  input  logic [rbs_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [10:0] slot_index, [42:11] sent_data_total, [74:43] sent_status_total,
  // [106:75] stamp, [138:107] dropped, [143:139] zero
  output logic [rbs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] send_kind, [1] pipelined
  output logic [rbs_pkg::OUT_TUSER_W-1:0]     out_tuser,
  // last_of_run
  output logic                                out_tlast
);
  import rbs_pkg::*;

  rbs_cmd_t cmd;
  rbs_sts_t sts;

  assign cfg_ready = 1'b1;

  rbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
